>>> rtl/tas_pkg.sv
// ----------------------------------------------------------------------------
// tas_pkg
// Shared constants, types and helpers of the triangle affine solver.
// ----------------------------------------------------------------------------
package tas_pkg;

  // coefficient format, signed q24.24
  localparam int COEF_W     = 48;
  localparam int LIN_SHIFT  = 24;
  localparam int TR_SHIFT   = 8;

  // 0.00001 at scale 2^-32
  localparam int EPS_RAW    = 42950;

  // multiplier operand chunk
  localparam int MUL_CHUNK  = 16;

  // divider pipeline: abs, range check, one stage per bit, round and saturate
  localparam int DIV_LAT    = COEF_W + 3;

  // queue between front and back
  localparam int QDEPTH     = 4;

  // register index, taken from paddr[2]
  localparam logic CFG_IDX_SEGMENT_MODE = 1'b0;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic int mul_lat(input int bw);
    return (bw + MUL_CHUNK - 1) / MUL_CHUNK + 2;
  endfunction

endpackage

>>> rtl/triangle_affine_solver.sv
// ----------------------------------------------------------------------------
// triangle_affine_solver
// Affine map from three source/destination point pairs.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one triangle pair per beat: twelve
// signed Q16.16 coordinates. Output channel out_valid/out_ready returns one
// beat per input: six signed Q24.24 coefficients, saturated, and the
// degenerate flag raised when the determinant was clamped to epsilon.
// The APB port holds segment_mode at address 0; with it set the third points
// are derived from the first two by a 90 degree turn.
// Throughput is one beat per cycle while no output waits on out_ready. The
// 48 quotient-bit stages of the dividers make up most of the solve pipeline.
// A short queue sits between the input stage and the solve pipeline. When
// out_valid is high and out_ready is low the solve pipeline holds, the queue
// fills, and in_ready drops once the queue and the input stage are full.
// Reset clears segment_mode, the queue and all valid state.
// ----------------------------------------------------------------------------
module triangle_affine_solver #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       src_x0,
  input  logic signed [COORD_WIDTH-1:0]       src_y0,
  input  logic signed [COORD_WIDTH-1:0]       src_x1,
  input  logic signed [COORD_WIDTH-1:0]       src_y1,
  input  logic signed [COORD_WIDTH-1:0]       src_x2,
  input  logic signed [COORD_WIDTH-1:0]       src_y2,
  input  logic signed [COORD_WIDTH-1:0]       dst_x0,
  input  logic signed [COORD_WIDTH-1:0]       dst_y0,
  input  logic signed [COORD_WIDTH-1:0]       dst_x1,
  input  logic signed [COORD_WIDTH-1:0]       dst_y1,
  input  logic signed [COORD_WIDTH-1:0]       dst_x2,
  input  logic signed [COORD_WIDTH-1:0]       dst_y2,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tas_pkg::COEF_W-1:0]   coef_xx,
  output logic signed [tas_pkg::COEF_W-1:0]   coef_xy,
  output logic signed [tas_pkg::COEF_W-1:0]   coef_xt,
  output logic signed [tas_pkg::COEF_W-1:0]   coef_yx,
  output logic signed [tas_pkg::COEF_W-1:0]   coef_yy,
  output logic signed [tas_pkg::COEF_W-1:0]   coef_yt,
  output logic                                degenerate
);

  localparam int SW = COORD_WIDTH + 2;

  logic segment_mode;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == tas_pkg::CFG_IDX_SEGMENT_MODE) begin
      segment_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == tas_pkg::CFG_IDX_SEGMENT_MODE) ?
                  {31'b0, segment_mode} : 32'b0;

  tas_pkg::q_stat_t    stat;
  logic                push;
  logic                pop;
  logic [11:0][SW-1:0] f_pts;
  logic [11:0][SW-1:0] head;

  tas_front #(.W(COORD_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .segment_mode (segment_mode),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .src_x0       (src_x0),
    .src_y0       (src_y0),
    .src_x1       (src_x1),
    .src_y1       (src_y1),
    .src_x2       (src_x2),
    .src_y2       (src_y2),
    .dst_x0       (dst_x0),
    .dst_y0       (dst_y0),
    .dst_x1       (dst_x1),
    .dst_y1       (dst_y1),
    .dst_x2       (dst_x2),
    .dst_y2       (dst_y2),
    .stat         (stat),
    .push         (push),
    .pts          (f_pts)
  );

  tas_fifo #(.WIDTH(12 * SW)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (f_pts),
    .pop   (pop),
    .rdata (head),
    .stat  (stat)
  );

  tas_back #(.W(COORD_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .stat       (stat),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .coef_xx    (coef_xx),
    .coef_xy    (coef_xy),
    .coef_xt    (coef_xt),
    .coef_yx    (coef_yx),
    .coef_yy    (coef_yy),
    .coef_yt    (coef_yt),
    .degenerate (degenerate)
  );

endmodule

>>> rtl/tas_dly.sv
// ----------------------------------------------------------------------------
// tas_dly
// Enabled shift line that keeps side data aligned with the math pipeline.
// ----------------------------------------------------------------------------
module tas_dly #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        sr[k] <= sr[k-1];
      end
    end
  end

  assign q = sr[DEPTH-1];

endmodule

>>> rtl/tas_mul.sv
// ----------------------------------------------------------------------------
// tas_mul
// Pipelined signed multiplier, one 16-bit chunk of b per stage.
// ----------------------------------------------------------------------------
module tas_mul #(
  parameter int AW = 34,
  parameter int BW = 34
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int CH  = tas_pkg::MUL_CHUNK;
  localparam int NCH = (BW + CH - 1) / CH;
  localparam int BP  = NCH * CH;
  localparam int PW  = AW + BW;

  logic [AW-1:0] am  [NCH+1];
  logic [BP-1:0] bm  [NCH+1];
  logic [PW-1:0] acc [NCH+1];
  logic          ng  [NCH+1];
  logic [BW-1:0] babs;

  assign babs = b[BW-1] ? (~b + BW'(1)) : b;

  always_ff @(posedge clk) begin
    if (en) begin
      am[0]  <= a[AW-1] ? (~a + AW'(1)) : a;
      bm[0]  <= BP'(babs);
      ng[0]  <= a[AW-1] ^ b[BW-1];
      acc[0] <= '0;
    end
  end

  for (genvar k = 0; k < NCH; k++) begin : g_stage
    logic [AW+CH-1:0] term;
    assign term = am[k] * bm[k][k*CH +: CH];
    always_ff @(posedge clk) begin
      if (en) begin
        am[k+1]  <= am[k];
        bm[k+1]  <= bm[k];
        ng[k+1]  <= ng[k];
        acc[k+1] <= acc[k] + (PW'(term) << (k * CH));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= ng[NCH] ? (~acc[NCH] + PW'(1)) : acc[NCH];
    end
  end

endmodule

>>> rtl/tas_div.sv
// ----------------------------------------------------------------------------
// tas_div
// Pipelined restoring divider, one quotient bit per stage, rounded to
// nearest with ties away from zero and saturated to the coefficient range.
// ----------------------------------------------------------------------------
module tas_div #(
  parameter int NW = 95,
  parameter int DW = 71
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [NW-1:0]          num,
  input  logic signed [DW-1:0]          den,
  output logic signed [tas_pkg::COEF_W-1:0] q
);

  localparam int QB = tas_pkg::COEF_W;
  localparam int RW = DW + QB;
  localparam int CW = (NW > RW) ? NW : RW;

  logic [NW-1:0] n0;
  logic [DW-1:0] d0;
  logic          neg0;

  logic [RW-1:0] r   [QB+1];
  logic [DW-1:0] dd  [QB+1];
  logic [QB-1:0] qq  [QB+1];
  logic          ng  [QB+1];
  logic          big [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      n0   <= num[NW-1] ? (~num + NW'(1)) : num;
      d0   <= den[DW-1] ? (~den + DW'(1)) : den;
      neg0 <= num[NW-1] ^ den[DW-1];
      // quotient would need more than QB bits
      big[0] <= CW'(n0) >= (CW'(d0) << QB);
      r[0]   <= RW'(n0);
      dd[0]  <= d0;
      qq[0]  <= '0;
      ng[0]  <= neg0;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_bit
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(dd[j]) << (QB - 1 - j);
    assign ge  = r[j] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        r[j+1]   <= ge ? (r[j] - dsh) : r[j];
        qq[j+1]  <= {qq[j][QB-2:0], ge};
        dd[j+1]  <= dd[j];
        ng[j+1]  <= ng[j];
        big[j+1] <= big[j];
      end
    end
  end

  logic [QB:0] mag;
  logic        rnd;

  assign rnd = ((RW+1)'(r[QB]) << 1) >= (RW+1)'(dd[QB]);
  assign mag = {1'b0, qq[QB]} + (QB+1)'(rnd);

  always_ff @(posedge clk) begin
    if (en) begin
      if (ng[QB]) begin
        if (big[QB] || mag > ((QB+1)'(1) << (QB - 1))) begin
          q <= {1'b1, {(QB-1){1'b0}}};
        end else begin
          q <= ~mag[QB-1:0] + QB'(1);
        end
      end else begin
        if (big[QB] || mag >= ((QB+1)'(1) << (QB - 1))) begin
          q <= {1'b0, {(QB-1){1'b1}}};
        end else begin
          q <= mag[QB-1:0];
        end
      end
    end
  end

endmodule

>>> rtl/tas_fifo.sv
// ----------------------------------------------------------------------------
// tas_fifo
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module tas_fifo #(
  parameter int WIDTH = 408
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   wdata,
  input  logic               pop,
  output logic [WIDTH-1:0]   rdata,
  output tas_pkg::q_stat_t   stat
);

  localparam int DEPTH = tas_pkg::QDEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + CNTW'(push) - CNTW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  assign rdata      = mem[rd_ptr];
  assign stat.full  = count == CNTW'(DEPTH);
  assign stat.empty = count == '0;

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full) else $error("push into full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty) else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + CNTW'($past(push)) - CNTW'($past(pop)))
    else $error("queue fill count out of step");

endmodule

>>> rtl/tas_front.sv
// ----------------------------------------------------------------------------
// tas_front
// Input stage: takes triangle beats, derives the third points in segment
// mode, widens the coordinates and hands them to the queue.
// ----------------------------------------------------------------------------
module tas_front #(
  parameter int W = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     segment_mode,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [W-1:0]      src_x0,
  input  logic signed [W-1:0]      src_y0,
  input  logic signed [W-1:0]      src_x1,
  input  logic signed [W-1:0]      src_y1,
  input  logic signed [W-1:0]      src_x2,
  input  logic signed [W-1:0]      src_y2,
  input  logic signed [W-1:0]      dst_x0,
  input  logic signed [W-1:0]      dst_y0,
  input  logic signed [W-1:0]      dst_x1,
  input  logic signed [W-1:0]      dst_y1,
  input  logic signed [W-1:0]      dst_x2,
  input  logic signed [W-1:0]      dst_y2,
  input  tas_pkg::q_stat_t         stat,
  output logic                     push,
  output logic [11:0][W+1:0]       pts
);

  localparam int SW = W + 2;

  logic              f_valid;
  logic [11:0][SW-1:0] pts_next;

  always_comb begin
    pts_next[0]  = SW'(src_x0);
    pts_next[1]  = SW'(src_y0);
    pts_next[2]  = SW'(src_x1);
    pts_next[3]  = SW'(src_y1);
    pts_next[6]  = SW'(dst_x0);
    pts_next[7]  = SW'(dst_y0);
    pts_next[8]  = SW'(dst_x1);
    pts_next[9]  = SW'(dst_y1);
    if (segment_mode) begin
      // p2 = p0 + rot90(p1 - p0), kept at full width
      pts_next[4]  = SW'(src_x0) - SW'(src_y1) + SW'(src_y0);
      pts_next[5]  = SW'(src_y0) + SW'(src_x1) - SW'(src_x0);
      pts_next[10] = SW'(dst_x0) - SW'(dst_y1) + SW'(dst_y0);
      pts_next[11] = SW'(dst_y0) + SW'(dst_x1) - SW'(dst_x0);
    end else begin
      pts_next[4]  = SW'(src_x2);
      pts_next[5]  = SW'(src_y2);
      pts_next[10] = SW'(dst_x2);
      pts_next[11] = SW'(dst_y2);
    end
  end

  assign in_ready = !f_valid || !stat.full;
  assign push     = f_valid && !stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pts <= pts_next;
    end
  end

endmodule

>>> rtl/tas_back.sv
// ----------------------------------------------------------------------------
// tas_back
// Solve pipeline: cofactors, determinant with epsilon clamp, cofactor sums,
// six pipelined divisions and the output register.
// ----------------------------------------------------------------------------
module tas_back #(
  parameter int W = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tas_pkg::q_stat_t                   stat,
  input  logic [11:0][W+1:0]                 head,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tas_pkg::COEF_W-1:0]  coef_xx,
  output logic signed [tas_pkg::COEF_W-1:0]  coef_xy,
  output logic signed [tas_pkg::COEF_W-1:0]  coef_xt,
  output logic signed [tas_pkg::COEF_W-1:0]  coef_yx,
  output logic signed [tas_pkg::COEF_W-1:0]  coef_yy,
  output logic signed [tas_pkg::COEF_W-1:0]  coef_yt,
  output logic                               degenerate
);

  localparam int SW   = W + 2;
  localparam int MW   = W + 3;
  localparam int PDW  = 2 * SW;
  localparam int PLW  = MW + SW;
  localparam int M6W  = PDW + 1;
  localparam int LNW  = PLW + 2;
  localparam int DETW = M6W + 2;
  localparam int PTW  = M6W + SW;
  localparam int TNW  = PTW + 2;
  localparam int L1   = tas_pkg::mul_lat(SW);
  localparam int DL   = tas_pkg::DIV_LAT;
  localparam int LT   = 3 + 2 * L1 + DL;

  localparam int DA [6] = '{2, 4, 4, 0, 0, 2};
  localparam int DB [6] = '{5, 3, 1, 5, 3, 1};

  logic          en;
  logic [LT:1]   v;

  assign en        = !v[LT] || out_ready;
  assign pop       = en && !stat.empty;
  assign out_valid = v[LT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[LT-1:1], pop};
    end
  end

  // first level: points and first-order cofactors
  logic [5:0][SW-1:0]     s1;
  logic [5:0][SW-1:0]     t1;
  logic signed [MW-1:0]   m1 [6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        s1[k] <= head[k];
        t1[k] <= head[6+k];
      end
      m1[0] <= MW'($signed(head[3])) - MW'($signed(head[5]));
      m1[1] <= MW'($signed(head[5])) - MW'($signed(head[1]));
      m1[2] <= MW'($signed(head[1])) - MW'($signed(head[3]));
      m1[3] <= MW'($signed(head[4])) - MW'($signed(head[2]));
      m1[4] <= MW'($signed(head[0])) - MW'($signed(head[4]));
      m1[5] <= MW'($signed(head[2])) - MW'($signed(head[0]));
    end
  end

  logic signed [PDW-1:0] pd [6];
  logic signed [PLW-1:0] pl [2][6];

  for (genvar k = 0; k < 6; k++) begin : g_det_mul
    tas_mul #(.AW(SW), .BW(SW)) u_mul (
      .clk (clk),
      .en  (en),
      .a   ($signed(s1[DA[k]])),
      .b   ($signed(s1[DB[k]])),
      .p   (pd[k])
    );
  end

  for (genvar i = 0; i < 2; i++) begin : g_lin_row
    for (genvar j = 0; j < 6; j++) begin : g_lin_mul
      tas_mul #(.AW(MW), .BW(SW)) u_mul (
        .clk (clk),
        .en  (en),
        .a   (m1[j]),
        .b   ($signed(t1[2 * (j % 3) + i])),
        .p   (pl[i][j])
      );
    end
  end

  logic [5:0][SW-1:0] td;

  tas_dly #(.WIDTH(6 * SW), .DEPTH(L1 + 1)) u_t_dly (
    .clk (clk),
    .en  (en),
    .d   (t1),
    .q   (td)
  );

  // second level: second-order cofactors and linear sums
  logic signed [M6W-1:0] m6 [3];
  logic signed [LNW-1:0] nl [2][2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m6[k] <= M6W'(pd[2*k]) - M6W'(pd[2*k+1]);
      end
      for (int i = 0; i < 2; i++) begin
        for (int h = 0; h < 2; h++) begin
          nl[i][h] <= LNW'(pl[i][3*h]) + LNW'(pl[i][3*h+1]) + LNW'(pl[i][3*h+2]);
        end
      end
    end
  end

  logic signed [PTW-1:0] pt [2][3];

  for (genvar i = 0; i < 2; i++) begin : g_tr_row
    for (genvar k = 0; k < 3; k++) begin : g_tr_mul
      tas_mul #(.AW(M6W), .BW(SW)) u_mul (
        .clk (clk),
        .en  (en),
        .a   (m6[k]),
        .b   ($signed(td[2 * k + i])),
        .p   (pt[i][k])
      );
    end
  end

  // determinant and epsilon clamp
  logic signed [DETW-1:0] det;
  logic signed [DETW-1:0] detc;
  logic                   degen;
  logic [DETW-1:0]        dabs;
  logic                   small_d;

  assign dabs    = det[DETW-1] ? (~det + DETW'(1)) : det;
  assign small_d = dabs < DETW'(tas_pkg::EPS_RAW);

  always_ff @(posedge clk) begin
    if (en) begin
      det   <= DETW'(m6[0]) + DETW'(m6[1]) + DETW'(m6[2]);
      degen <= small_d;
      if (small_d) begin
        // zero clamps to the positive side
        detc <= det[DETW-1] ? -DETW'(tas_pkg::EPS_RAW) : DETW'(tas_pkg::EPS_RAW);
      end else begin
        detc <= det;
      end
    end
  end

  logic [DETW:0] dg_d;

  tas_dly #(.WIDTH(DETW + 1), .DEPTH(L1 - 1)) u_det_dly (
    .clk (clk),
    .en  (en),
    .d   ({degen, detc}),
    .q   (dg_d)
  );

  logic [4*LNW-1:0] nl_d;

  tas_dly #(.WIDTH(4 * LNW), .DEPTH(L1 + 1)) u_nl_dly (
    .clk (clk),
    .en  (en),
    .d   ({nl[1][1], nl[1][0], nl[0][1], nl[0][0]}),
    .q   (nl_d)
  );

  // translation sums
  logic signed [TNW-1:0] nt [2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        nt[i] <= TNW'(pt[i][0]) + TNW'(pt[i][1]) + TNW'(pt[i][2]);
      end
    end
  end

  logic signed [tas_pkg::COEF_W-1:0] ql [4];
  logic signed [tas_pkg::COEF_W-1:0] qt [2];

  for (genvar k = 0; k < 4; k++) begin : g_lin_div
    tas_div #(.NW(LNW + tas_pkg::LIN_SHIFT), .DW(DETW)) u_div (
      .clk (clk),
      .en  (en),
      .num ($signed({nl_d[k*LNW +: LNW], {tas_pkg::LIN_SHIFT{1'b0}}})),
      .den ($signed(dg_d[DETW-1:0])),
      .q   (ql[k])
    );
  end

  for (genvar i = 0; i < 2; i++) begin : g_tr_div
    tas_div #(.NW(TNW + tas_pkg::TR_SHIFT), .DW(DETW)) u_div (
      .clk (clk),
      .en  (en),
      .num ($signed({nt[i], {tas_pkg::TR_SHIFT{1'b0}}})),
      .den ($signed(dg_d[DETW-1:0])),
      .q   (qt[i])
    );
  end

  tas_dly #(.WIDTH(1), .DEPTH(DL)) u_dg_dly (
    .clk (clk),
    .en  (en),
    .d   (dg_d[DETW]),
    .q   (degenerate)
  );

  assign coef_xx = ql[0];
  assign coef_xy = ql[1];
  assign coef_xt = qt[0];
  assign coef_yx = ql[2];
  assign coef_yy = ql[3];
  assign coef_yt = qt[1];

endmodule
